[rtl/hpq_pkg.sv]
// Shared types, codes and helpers for the binary heap priority queue.
package hpq_pkg;

   localparam int KEY_W = 32;
   localparam int CNT_W = 7;
   localparam int PW    = CNT_W + 1;
   localparam int CNT_MAX = (1 << CNT_W) - 1;

   localparam logic KIND_INSERT  = 1'b0;
   localparam logic KIND_EXTRACT = 1'b1;

   localparam logic REG_MAX_ORDER = 1'b0;
   localparam logic REG_CAP_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHK,
      S_UP_CMP,
      S_EX_LAST,
      S_EX_LOAD,
      S_DN_CHK,
      S_DN_RDR,
      S_DN_CMP,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_ROOT,
      RD_LAST,
      RD_PARENT,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_KEY,
      WR_RD,
      WR_BEST
   } wr_sel_type;

   typedef enum logic [2:0] {
      POS_HOLD,
      POS_NEXT,
      POS_ROOT,
      POS_PARENT,
      POS_BEST
   } pos_sel_type;

   typedef struct packed {
      logic        start;
      logic        err_full;
      logic        err_empty;
      logic        load_key;
      logic        key_from_rd;
      logic        root_cap;
      logic        lval_cap;
      logic        count_inc;
      logic        count_dec;
      logic        out_load;
      rd_sel_type  rd_sel;
      wr_sel_type  wr_sel;
      pos_sel_type pos_sel;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_root;
      logic left_out;
      logic right_in;
      logic up_swap;
      logic stay;
      logic cnt_zero;
   } flags_type;

   // true when key a belongs above key b
   function automatic logic outranks(logic max_order, logic [KEY_W-1:0] a,
                                     logic [KEY_W-1:0] b);
      return max_order ? (a > b) : (a < b);
   endfunction

endpackage

[rtl/hpq_ctrl.sv]
// Sequencer for insert and extract: handshakes and per-level sift steps.
module hpq_ctrl import hpq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  logic      req_kind,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   input  flags_type flags,
   output cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               if (req_kind == KIND_INSERT) begin
                  if (flags.full) begin
                     cmd.err_full = 1'b1;
                     state_in     = S_DONE;
                  end else begin
                     cmd.load_key  = 1'b1;
                     cmd.pos_sel   = POS_NEXT;
                     cmd.count_inc = 1'b1;
                     state_in      = S_UP_CHK;
                  end
               end else begin
                  if (flags.empty) begin
                     cmd.err_empty = 1'b1;
                     state_in      = S_DONE;
                  end else begin
                     cmd.rd_sel = RD_ROOT;
                     state_in   = S_EX_LAST;
                  end
               end
            end
         end
         S_UP_CHK: begin
            if (flags.pos_root) begin
               cmd.wr_sel = WR_KEY;
               state_in   = S_DONE;
            end else begin
               cmd.rd_sel = RD_PARENT;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (flags.up_swap) begin
               cmd.wr_sel  = WR_RD;
               cmd.pos_sel = POS_PARENT;
               state_in    = S_UP_CHK;
            end else begin
               cmd.wr_sel = WR_KEY;
               state_in   = S_DONE;
            end
         end
         S_EX_LAST: begin
            cmd.root_cap  = 1'b1;
            cmd.rd_sel    = RD_LAST;
            cmd.count_dec = 1'b1;
            state_in      = S_EX_LOAD;
         end
         S_EX_LOAD: begin
            cmd.key_from_rd = 1'b1;
            cmd.pos_sel     = POS_ROOT;
            state_in        = flags.cnt_zero ? S_DONE : S_DN_CHK;
         end
         S_DN_CHK: begin
            if (flags.left_out) begin
               cmd.wr_sel = WR_KEY;
               state_in   = S_DONE;
            end else begin
               cmd.rd_sel = RD_LEFT;
               state_in   = S_DN_RDR;
            end
         end
         S_DN_RDR: begin
            cmd.lval_cap = 1'b1;
            if (flags.right_in) begin
               cmd.rd_sel = RD_RIGHT;
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (flags.stay) begin
               cmd.wr_sel = WR_KEY;
               state_in   = S_DONE;
            end else begin
               cmd.wr_sel  = WR_BEST;
               cmd.pos_sel = POS_BEST;
               state_in    = S_DN_CHK;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/hpq_dp.sv]
// Heap datapath: key memory, sift registers, compares and result register.
module hpq_dp import hpq_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output flags_type        flags,
   input  logic             max_order,
   input  logic [CNT_W-1:0] cap_limit,
   input  logic [KEY_W-1:0] req_new_key,
   output logic [KEY_W-1:0] rsp_root_key,
   output logic [1:0]       rsp_status,
   output logic [CNT_W-1:0] rsp_fill_count
);

   localparam int AW = $clog2(CAPACITY + 1);
   localparam int CAP_SAT_I = (CAPACITY > CNT_MAX) ? CNT_MAX : CAPACITY;
   localparam logic [CNT_W-1:0] CAP_SAT = CNT_W'(CAP_SAT_I);

   logic [KEY_W-1:0] mem [0:CAPACITY];

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] lval_ff, lval_in;
   logic [KEY_W-1:0] root_ff, root_in;
   status_type       status_ff, status_in;
   logic [KEY_W-1:0] rd_data_ff;
   logic [KEY_W-1:0] out_root_ff;
   status_type       out_status_ff;
   logic [CNT_W-1:0] out_fill_ff;

   logic [CNT_W-1:0] limit;
   logic [PW-1:0]    cnt_x, lc, rc, parent, best_pos, rd_pos;
   logic [KEY_W-1:0] best_val, cur_val, wr_data;
   logic             take_l, take_r, we;

   function automatic logic [AW-1:0] to_addr(logic [PW-1:0] p);
      logic [AW+PW-1:0] w;
      w = {{AW{1'b0}}, p};
      return w[AW-1:0];
   endfunction

   assign limit  = (cap_limit < CAP_SAT) ? cap_limit : CAP_SAT;
   assign cnt_x  = {1'b0, cnt_ff};
   assign lc     = {pos_ff[PW-2:0], 1'b0};
   assign rc     = {pos_ff[PW-2:0], 1'b1};
   assign parent = pos_ff >> 1;

   assign take_l   = outranks(max_order, lval_ff, key_ff);
   assign cur_val  = take_l ? lval_ff : key_ff;
   assign take_r   = (rc <= cnt_x) && outranks(max_order, rd_data_ff, cur_val);
   assign best_pos = take_r ? rc : (take_l ? lc : pos_ff);
   assign best_val = take_r ? rd_data_ff : lval_ff;

   always_comb begin
      flags.full     = (cnt_ff >= limit);
      flags.empty    = (cnt_ff == '0) || (cnt_ff > CAP_SAT);
      flags.pos_root = (pos_ff == PW'(1));
      flags.left_out = (lc > cnt_x);
      flags.right_in = (rc <= cnt_x);
      flags.up_swap  = outranks(max_order, key_ff, rd_data_ff);
      flags.stay     = !take_l && !take_r;
      flags.cnt_zero = (cnt_ff == '0);
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_ROOT:   rd_pos = PW'(1);
         RD_LAST:   rd_pos = cnt_x;
         RD_PARENT: rd_pos = parent;
         RD_LEFT:   rd_pos = lc;
         RD_RIGHT:  rd_pos = rc;
         default:   rd_pos = PW'(1);
      endcase
   end

   always_comb begin
      we = 1'b1;
      case (cmd.wr_sel)
         WR_KEY:  wr_data = key_ff;
         WR_RD:   wr_data = rd_data_ff;
         WR_BEST: wr_data = best_val;
         default: begin
            wr_data = key_ff;
            we      = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (cmd.pos_sel)
         POS_NEXT:   pos_in = cnt_x + PW'(1);
         POS_ROOT:   pos_in = PW'(1);
         POS_PARENT: pos_in = parent;
         POS_BEST:   pos_in = best_pos;
         default:    pos_in = pos_ff;
      endcase
   end

   always_comb begin
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      lval_in   = lval_ff;
      root_in   = root_ff;
      status_in = status_ff;
      if (cmd.count_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (cmd.load_key) begin
         key_in = req_new_key;
      end else if (cmd.key_from_rd) begin
         key_in = rd_data_ff;
      end
      if (cmd.lval_cap) begin
         lval_in = rd_data_ff;
      end
      if (cmd.start) begin
         root_in = '0;
         if (cmd.err_full) begin
            status_in = ST_FULL;
         end else if (cmd.err_empty) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_DONE;
         end
      end else if (cmd.root_cap) begin
         root_in = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      key_ff    <= key_in;
      lval_ff   <= lval_in;
      root_ff   <= root_in;
      status_ff <= status_in;
      if (cmd.out_load) begin
         out_root_ff   <= root_ff;
         out_status_ff <= status_ff;
         out_fill_ff   <= cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[to_addr(pos_ff)] <= wr_data;
      end
      if (cmd.rd_sel != RD_NONE) begin
         rd_data_ff <= mem[to_addr(rd_pos)];
      end
   end

   assign rsp_root_key   = out_root_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_fill_count = out_fill_ff;

endmodule

[rtl/binary_heap_priority_queue.sv]
// Binary heap priority queue top level: register port, sequencer and datapath.
// Holds up to CAPACITY 32-bit unsigned keys (never more than capacity_limit) in one
// single-port key memory with registered read data. One operation is worked at a
// time. An insert lets the new key climb level by level from the next free slot;
// an extract reports the root, moves the last key to the root and, unless that
// empties the heap, lets it sink level by level. Each level costs one or two
// memory reads with registered data. A finished result sits in the output register
// while the next request is taken, and stays put while rsp_stall is high.
module binary_heap_priority_queue import hpq_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_kind,
   input  logic [KEY_W-1:0] req_new_key,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [KEY_W-1:0] rsp_root_key,
   output logic [1:0]       rsp_status,
   output logic [CNT_W-1:0] rsp_fill_count,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic             max_order_ff, max_order_in;
   logic [CNT_W-1:0] cap_limit_ff, cap_limit_in;
   logic             csr_wr;
   cmd_type          cmd;
   flags_type        flags;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      max_order_in = max_order_ff;
      cap_limit_in = cap_limit_ff;
      if (csr_wr) begin
         case (paddr[2])
            REG_MAX_ORDER: max_order_in = pwdata[0];
            REG_CAP_LIMIT: cap_limit_in = pwdata[CNT_W-1:0];
            default:       max_order_in = max_order_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_MAX_ORDER: prdata = {31'b0, max_order_ff};
         REG_CAP_LIMIT: prdata = {{(32-CNT_W){1'b0}}, cap_limit_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_order_ff <= 1'b1;
         cap_limit_ff <= CNT_W'(64);
      end else begin
         max_order_ff <= max_order_in;
         cap_limit_ff <= cap_limit_in;
      end
   end

   hpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   hpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .flags          (flags),
      .max_order      (max_order_ff),
      .cap_limit      (cap_limit_ff),
      .req_new_key    (req_new_key),
      .rsp_root_key   (rsp_root_key),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

   // one operation at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while an operation is in flight");

   // refused transfers carry a zero key
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DONE) |-> (rsp_root_key == '0))
      else $error("refused operation reports a key");

   // empty refusal only with nothing stored
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_fill_count == '0))
      else $error("empty refusal with keys stored");

endmodule
